// File: hw/rtl/association_protocol_fsm_defines.svh
// Assertion helpers shared by the RTL of the association control block.
// Both forms are sampled on the rising clock edge and are off while reset is low.
`ifndef ASSOCIATION_PROTOCOL_FSM_DEFINES_SVH
`define ASSOCIATION_PROTOCOL_FSM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/asc_fsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package asc_fsm_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int CFG_W          = 16;

    // Request kinds
    localparam logic [1:0] REQ_RAW    = 2'd0;
    localparam logic [1:0] REQ_LOCAL  = 2'd1;
    localparam logic [1:0] REQ_REMOTE = 2'd2;
    localparam logic [1:0] REQ_TICK   = 2'd3;

    // PDU type bytes
    localparam logic [7:0] PDU_ASSOC_RQ = 8'h01;
    localparam logic [7:0] PDU_ASSOC_AC = 8'h02;
    localparam logic [7:0] PDU_ASSOC_RJ = 8'h03;
    localparam logic [7:0] PDU_DATA_TF  = 8'h04;
    localparam logic [7:0] PDU_REL_RQ   = 8'h05;
    localparam logic [7:0] PDU_REL_RP   = 8'h06;
    localparam logic [7:0] PDU_ABORT    = 8'h07;

    // Events
    localparam logic [4:0] EV_RQ_LOC    = 5'd0;
    localparam logic [4:0] EV_TC_IND    = 5'd1;
    localparam logic [4:0] EV_AC_REM    = 5'd2;
    localparam logic [4:0] EV_RJ_REM    = 5'd3;
    localparam logic [4:0] EV_RQ_REM    = 5'd4;
    localparam logic [4:0] EV_DT_REM    = 5'd5;
    localparam logic [4:0] EV_RLQ_REM   = 5'd6;
    localparam logic [4:0] EV_RLP_REM   = 5'd7;
    localparam logic [4:0] EV_AB_REM    = 5'd8;
    localparam logic [4:0] EV_TC_CLOSED = 5'd9;
    localparam logic [4:0] EV_ARTIM     = 5'd10;
    localparam logic [4:0] EV_INVALID   = 5'd11;
    localparam logic [4:0] EV_AC_LOC    = 5'd12;
    localparam logic [4:0] EV_RJ_LOC    = 5'd13;
    localparam logic [4:0] EV_AB_LOC    = 5'd14;
    localparam logic [4:0] EV_TC_CONF   = 5'd15;
    localparam logic [4:0] EV_DT_LOC    = 5'd16;
    localparam logic [4:0] EV_RLQ_LOC   = 5'd17;
    localparam logic [4:0] EV_RLP_LOC   = 5'd18;

    // Actions
    localparam logic [4:0] AE_1  = 5'd0;
    localparam logic [4:0] AE_2  = 5'd1;
    localparam logic [4:0] AE_3  = 5'd2;
    localparam logic [4:0] AE_4  = 5'd3;
    localparam logic [4:0] AE_5  = 5'd4;
    localparam logic [4:0] AE_6  = 5'd5;
    localparam logic [4:0] AE_7  = 5'd6;
    localparam logic [4:0] AE_8  = 5'd7;
    localparam logic [4:0] DT_1  = 5'd8;
    localparam logic [4:0] DT_2  = 5'd9;
    localparam logic [4:0] AR_1  = 5'd10;
    localparam logic [4:0] AR_2  = 5'd11;
    localparam logic [4:0] AR_3  = 5'd12;
    localparam logic [4:0] AR_4  = 5'd13;
    localparam logic [4:0] AR_5  = 5'd14;
    localparam logic [4:0] AR_6  = 5'd15;
    localparam logic [4:0] AR_7  = 5'd16;
    localparam logic [4:0] AR_9  = 5'd18;
    localparam logic [4:0] AR_10 = 5'd19;
    localparam logic [4:0] AA_1  = 5'd20;
    localparam logic [4:0] AA_2  = 5'd21;
    localparam logic [4:0] AA_3  = 5'd22;
    localparam logic [4:0] AA_4  = 5'd23;
    localparam logic [4:0] AA_5  = 5'd24;
    localparam logic [4:0] AA_6  = 5'd25;
    localparam logic [4:0] AA_7  = 5'd26;
    localparam logic [4:0] AA_8  = 5'd27;

    // Protocol states Sta1..Sta13
    localparam logic [3:0] ST_S1  = 4'd0;
    localparam logic [3:0] ST_S2  = 4'd1;
    localparam logic [3:0] ST_S3  = 4'd2;
    localparam logic [3:0] ST_S4  = 4'd3;
    localparam logic [3:0] ST_S5  = 4'd4;
    localparam logic [3:0] ST_S6  = 4'd5;
    localparam logic [3:0] ST_S7  = 4'd6;
    localparam logic [3:0] ST_S8  = 4'd7;
    localparam logic [3:0] ST_S9  = 4'd8;
    localparam logic [3:0] ST_S10 = 4'd9;
    localparam logic [3:0] ST_S11 = 4'd10;
    localparam logic [3:0] ST_S12 = 4'd11;
    localparam logic [3:0] ST_S13 = 4'd12;

    typedef struct packed {
        logic       hit;
        logic [4:0] act;
        logic [3:0] nxt;
    } t_trans;

    typedef struct packed {
        logic       hit;
        logic [4:0] act;
        logic [3:0] nxt;
        logic       start;
        logic       stop;
    } t_step;

    typedef struct packed {
        logic [4:0] action_code;
        logic [4:0] applied_event;
        logic [3:0] new_state;
        logic       status;
        logic       timer_active;
        logic       last;
    } t_res;

    function automatic t_trans mk(input logic [4:0] act, input logic [3:0] nxt);
        t_trans r;
        r.hit = 1'b1;
        r.act = act;
        r.nxt = nxt;
        return r;
    endfunction

    function automatic logic [4:0] local_event(input logic [7:0] ptype);
        logic [4:0] ev;
        case (ptype)
            PDU_ASSOC_RQ: ev = EV_RQ_LOC;
            PDU_ASSOC_AC: ev = EV_AC_LOC;
            PDU_ASSOC_RJ: ev = EV_RJ_LOC;
            PDU_DATA_TF:  ev = EV_DT_LOC;
            PDU_REL_RQ:   ev = EV_RLQ_LOC;
            PDU_REL_RP:   ev = EV_RLP_LOC;
            PDU_ABORT:    ev = EV_AB_LOC;
            default:      ev = EV_INVALID;
        endcase
        return ev;
    endfunction

    function automatic logic [4:0] remote_event(input logic [7:0] ptype);
        logic [4:0] ev;
        case (ptype)
            PDU_ASSOC_RQ: ev = EV_RQ_REM;
            PDU_ASSOC_AC: ev = EV_AC_REM;
            PDU_ASSOC_RJ: ev = EV_RJ_REM;
            PDU_DATA_TF:  ev = EV_DT_REM;
            PDU_REL_RQ:   ev = EV_RLQ_REM;
            PDU_REL_RP:   ev = EV_RLP_REM;
            PDU_ABORT:    ev = EV_AB_REM;
            default:      ev = EV_INVALID;
        endcase
        return ev;
    endfunction

    // State transition table; a miss has hit low.
    function automatic t_trans trans_lookup(input logic [3:0] st, input logic [4:0] ev);
        t_trans r;
        r = '0;
        case (st)
            ST_S1: begin
                case (ev)
                    EV_RQ_LOC: r = mk(AE_1, ST_S4);
                    EV_TC_IND: r = mk(AE_5, ST_S2);
                    default:   r = '0;
                endcase
            end
            ST_S2: begin
                case (ev)
                    EV_AC_REM, EV_RJ_REM, EV_DT_REM, EV_RLQ_REM, EV_RLP_REM,
                    EV_INVALID:   r = mk(AA_1, ST_S13);
                    EV_RQ_REM:    r = mk(AE_6, ST_S3);
                    EV_AB_REM:    r = mk(AA_2, ST_S1);
                    EV_TC_CLOSED: r = mk(AA_5, ST_S1);
                    EV_ARTIM:     r = mk(AA_2, ST_S1);
                    default:      r = '0;
                endcase
            end
            ST_S3: begin
                case (ev)
                    EV_AC_REM, EV_RJ_REM, EV_RQ_REM, EV_DT_REM, EV_RLQ_REM, EV_RLP_REM,
                    EV_INVALID:   r = mk(AA_8, ST_S13);
                    EV_AC_LOC:    r = mk(AE_7, ST_S6);
                    EV_RJ_LOC:    r = mk(AE_8, ST_S13);
                    EV_AB_LOC:    r = mk(AA_1, ST_S13);
                    EV_AB_REM:    r = mk(AA_3, ST_S1);
                    EV_TC_CLOSED: r = mk(AA_4, ST_S1);
                    default:      r = '0;
                endcase
            end
            ST_S4: begin
                case (ev)
                    EV_TC_CONF:   r = mk(AE_2, ST_S5);
                    EV_AB_LOC:    r = mk(AA_2, ST_S1);
                    EV_TC_CLOSED: r = mk(AA_4, ST_S1);
                    default:      r = '0;
                endcase
            end
            ST_S5: begin
                case (ev)
                    EV_AC_REM:    r = mk(AE_3, ST_S6);
                    EV_RJ_REM:    r = mk(AE_4, ST_S1);
                    EV_RQ_REM, EV_DT_REM, EV_RLQ_REM, EV_RLP_REM,
                    EV_INVALID:   r = mk(AA_8, ST_S13);
                    EV_AB_LOC:    r = mk(AA_1, ST_S13);
                    EV_AB_REM:    r = mk(AA_3, ST_S1);
                    EV_TC_CLOSED: r = mk(AA_4, ST_S1);
                    default:      r = '0;
                endcase
            end
            ST_S6: begin
                case (ev)
                    EV_AC_REM, EV_RJ_REM, EV_RQ_REM, EV_RLP_REM,
                    EV_INVALID:   r = mk(AA_8, ST_S13);
                    EV_DT_LOC:    r = mk(DT_1, ST_S6);
                    EV_DT_REM:    r = mk(DT_2, ST_S6);
                    EV_RLQ_LOC:   r = mk(AR_1, ST_S7);
                    EV_RLQ_REM:   r = mk(AR_2, ST_S8);
                    EV_AB_LOC:    r = mk(AA_1, ST_S13);
                    EV_AB_REM:    r = mk(AA_3, ST_S1);
                    EV_TC_CLOSED: r = mk(AA_4, ST_S1);
                    default:      r = '0;
                endcase
            end
            ST_S7: begin
                // A remote release request here is a release collision, left unhandled.
                case (ev)
                    EV_AC_REM, EV_RJ_REM, EV_RQ_REM,
                    EV_INVALID:   r = mk(AA_8, ST_S13);
                    EV_DT_REM:    r = mk(AR_6, ST_S7);
                    EV_RLP_REM:   r = mk(AR_3, ST_S1);
                    EV_AB_LOC:    r = mk(AA_1, ST_S13);
                    EV_AB_REM:    r = mk(AA_3, ST_S1);
                    EV_TC_CLOSED: r = mk(AA_4, ST_S1);
                    default:      r = '0;
                endcase
            end
            ST_S8: begin
                case (ev)
                    EV_AC_REM, EV_RJ_REM, EV_RQ_REM, EV_DT_REM, EV_RLQ_REM, EV_RLP_REM,
                    EV_INVALID:   r = mk(AA_8, ST_S13);
                    EV_DT_LOC:    r = mk(AR_7, ST_S8);
                    EV_RLP_LOC:   r = mk(AR_4, ST_S13);
                    EV_AB_LOC:    r = mk(AA_1, ST_S13);
                    EV_AB_REM:    r = mk(AA_3, ST_S1);
                    EV_TC_CLOSED: r = mk(AA_4, ST_S1);
                    default:      r = '0;
                endcase
            end
            ST_S9: begin
                case (ev)
                    EV_AC_REM, EV_RJ_REM, EV_RQ_REM, EV_DT_REM, EV_RLQ_REM, EV_RLP_REM,
                    EV_INVALID:   r = mk(AA_8, ST_S13);
                    EV_RLP_LOC:   r = mk(AR_9, ST_S11);
                    EV_AB_LOC:    r = mk(AA_1, ST_S13);
                    EV_AB_REM:    r = mk(AA_3, ST_S1);
                    EV_TC_CLOSED: r = mk(AA_4, ST_S1);
                    default:      r = '0;
                endcase
            end
            ST_S10: begin
                case (ev)
                    EV_AC_REM, EV_RJ_REM, EV_RQ_REM, EV_DT_REM, EV_RLQ_REM,
                    EV_INVALID:   r = mk(AA_8, ST_S13);
                    EV_RLP_REM:   r = mk(AR_10, ST_S12);
                    EV_AB_LOC:    r = mk(AA_1, ST_S13);
                    EV_AB_REM:    r = mk(AA_3, ST_S1);
                    EV_TC_CLOSED: r = mk(AA_4, ST_S1);
                    default:      r = '0;
                endcase
            end
            ST_S11: begin
                case (ev)
                    EV_AC_REM, EV_RJ_REM, EV_RQ_REM, EV_DT_REM, EV_RLQ_REM,
                    EV_INVALID:   r = mk(AA_8, ST_S13);
                    EV_RLP_REM:   r = mk(AR_3, ST_S1);
                    EV_AB_LOC:    r = mk(AA_1, ST_S13);
                    EV_AB_REM:    r = mk(AA_3, ST_S1);
                    EV_TC_CLOSED: r = mk(AA_4, ST_S1);
                    default:      r = '0;
                endcase
            end
            ST_S12: begin
                case (ev)
                    EV_AC_REM, EV_RJ_REM, EV_RQ_REM, EV_DT_REM, EV_RLQ_REM, EV_RLP_REM,
                    EV_INVALID:   r = mk(AA_8, ST_S13);
                    EV_RLP_LOC:   r = mk(AR_4, ST_S13);
                    EV_AB_LOC:    r = mk(AA_1, ST_S13);
                    EV_AB_REM:    r = mk(AA_3, ST_S1);
                    EV_TC_CLOSED: r = mk(AA_4, ST_S1);
                    default:      r = '0;
                endcase
            end
            ST_S13: begin
                case (ev)
                    EV_AC_REM, EV_RJ_REM, EV_DT_REM, EV_RLQ_REM,
                    EV_RLP_REM:   r = mk(AA_6, ST_S13);
                    EV_RQ_REM,
                    EV_INVALID:   r = mk(AA_7, ST_S13);
                    EV_AB_REM:    r = mk(AA_2, ST_S1);
                    EV_TC_CLOSED: r = mk(AR_5, ST_S1);
                    EV_ARTIM:     r = mk(AA_2, ST_S1);
                    default:      r = '0;
                endcase
            end
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/asc_fsm_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface asc_fsm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [4:0] event_code;
    logic [7:0] pdu_byte;
    logic       association_acceptable;

    modport source (
        output valid, req_type, event_code, pdu_byte, association_acceptable,
        input  ready
    );
    modport sink (
        input  valid, req_type, event_code, pdu_byte, association_acceptable,
        output ready
    );
endinterface

interface asc_fsm_res_if;
    logic       valid;
    logic       ready;
    logic [4:0] action_code;
    logic [4:0] applied_event;
    logic [3:0] new_state;
    logic       status;
    logic       timer_active;
    logic       last;

    modport source (
        output valid, action_code, applied_event, new_state, status, timer_active, last,
        input  ready
    );
    modport sink (
        input  valid, action_code, applied_event, new_state, status, timer_active, last,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/asc_fsm_step.sv
`timescale 1ns / 1ps
`default_nettype none

module asc_fsm_step
    import asc_fsm_pkg::*;
(
    input  wire logic [3:0] i_state,
    input  wire logic [4:0] i_event,
    input  wire logic       i_guard,
    output t_step           o_step
);

    t_trans w_tr;

    always_comb begin
        w_tr         = trans_lookup(i_state, i_event);
        o_step.hit   = w_tr.hit;
        o_step.act   = w_tr.act;
        o_step.nxt   = w_tr.nxt;
        o_step.start = 1'b0;
        o_step.stop  = 1'b0;
        if (w_tr.hit) begin
            case (w_tr.act)
                // An unacceptable association request is rejected and waits
                // for the transport close under the timer.
                AE_6: begin
                    if (i_state == ST_S2 && !i_guard) begin
                        o_step.nxt   = ST_S13;
                        o_step.start = 1'b1;
                    end else begin
                        o_step.stop = 1'b1;
                    end
                end
                AE_5, AE_8, AR_4, AA_1, AA_8: o_step.start = 1'b1;
                AA_2, AA_5, AR_5:             o_step.stop  = 1'b1;
                default: begin
                    o_step.start = 1'b0;
                    o_step.stop  = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/asc_fsm_rq.sv
`timescale 1ns / 1ps
`default_nettype none

module asc_fsm_rq
    import asc_fsm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [1:0] i_push_n,
    input  wire t_res       i_ent0,
    input  wire t_res       i_ent1,
    output logic            o_room,
    asc_fsm_res_if.source   o_res
);

    localparam int DEPTH = 3;

    t_res       r_ent [DEPTH];
    t_res       n_ent [DEPTH];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic [1:0] w_base;
    logic       w_pop;

    // Room for a full two-item burst whatever the sink does this cycle.
    assign o_room = (r_cnt <= 2'd1);
    assign w_pop  = (r_cnt != 2'd0) && o_res.ready;

    always_comb begin
        n_ent  = r_ent;
        w_base = r_cnt - {1'b0, w_pop};
        if (w_pop) begin
            n_ent[0] = r_ent[1];
            n_ent[1] = r_ent[2];
        end
        if (i_push_n != 2'd0) begin
            n_ent[w_base] = i_ent0;
        end
        if (i_push_n == 2'd2) begin
            n_ent[w_base + 2'd1] = i_ent1;
        end
        n_cnt = w_base + i_push_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_res.valid         = (r_cnt != 2'd0);
    assign o_res.action_code   = r_ent[0].action_code;
    assign o_res.applied_event = r_ent[0].applied_event;
    assign o_res.new_state     = r_ent[0].new_state;
    assign o_res.status        = r_ent[0].status;
    assign o_res.timer_active  = r_ent[0].timer_active;
    assign o_res.last          = r_ent[0].last;

endmodule

`default_nettype wire

// File: hw/rtl/association_protocol_fsm.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Carries                                                  Accepted when
// i_req     in   req_type, event_code, pdu_byte, association_acceptable  valid && ready
// o_res     out  action_code, applied_event, new_state, status,
//                timer_active, last                                       valid && ready
// i_cfg     in   ARTIM length in ticks (one register)                     i_cfg_we
//
// An item is looked up in the transition table in the cycle it is accepted; its
// results enter the three-entry output queue at that same edge and are offered
// from the next cycle on.
// One item per cycle while the sink keeps up; a local association request
// that the current state accepts gives two results instead of one.
// Input ready follows the queue fill: it drops when two or more results wait.
// Synchronous reset returns to Sta1 with the timer stopped and the queue empty.

`include "association_protocol_fsm_defines.svh"

module association_protocol_fsm
    import asc_fsm_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    asc_fsm_req_if.sink           i_req,
    asc_fsm_res_if.source         o_res,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int LW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    logic [CFG_W-1:0]      r_artim;
    logic [3:0]            r_state;
    logic                  r_run;
    logic [TIMER_BITS-1:0] r_tcount;

    logic                  w_acc;
    logic                  w_room;
    logic [4:0]            w_ev;
    logic                  w_two_req;
    logic                  w_two;
    logic                  w_fire;
    logic                  w_apply;
    logic [LW-1:0]         w_cfg_ext;
    logic [LW-1:0]         w_lim;
    logic [TIMER_BITS-1:0] w_load;
    logic                  w_run0;
    logic [TIMER_BITS-1:0] w_cnt0;
    logic                  w_run1;
    logic [TIMER_BITS-1:0] w_cnt1;
    logic                  w_run2;
    logic [TIMER_BITS-1:0] w_cnt2;
    logic [1:0]            w_push_n;
    t_step                 w_s1;
    t_step                 w_s2;
    t_res                  w_ent0;
    t_res                  w_ent1;

    assign i_req.ready = w_room;
    assign w_acc       = i_req.valid && w_room;

    always_comb begin
        case (i_req.req_type)
            REQ_RAW:    w_ev = i_req.event_code;
            REQ_LOCAL:  w_ev = local_event(i_req.pdu_byte);
            REQ_REMOTE: w_ev = remote_event(i_req.pdu_byte);
            REQ_TICK:   w_ev = EV_ARTIM;
            default:    w_ev = EV_INVALID;
        endcase
    end

    // A local association request also confirms the transport at once.
    assign w_two_req = (i_req.req_type == REQ_LOCAL) && (i_req.pdu_byte == PDU_ASSOC_RQ);
    assign w_two     = w_two_req && w_s1.hit;
    assign w_fire    = (i_req.req_type == REQ_TICK) && r_run
                       && (r_tcount == TIMER_BITS'(1));
    assign w_apply   = (i_req.req_type != REQ_TICK) || w_fire;

    // The loaded count saturates when the counter is narrower than the register.
    assign w_cfg_ext = LW'(r_artim);
    assign w_lim     = LW'({TIMER_BITS{1'b1}});
    assign w_load    = (w_cfg_ext > w_lim) ? TIMER_BITS'(w_lim) : TIMER_BITS'(w_cfg_ext);

    asc_fsm_step u_step1 (
        .i_state (r_state),
        .i_event (w_ev),
        .i_guard (i_req.association_acceptable),
        .o_step  (w_s1)
    );

    asc_fsm_step u_step2 (
        .i_state (w_s1.nxt),
        .i_event (EV_TC_CONF),
        .i_guard (i_req.association_acceptable),
        .o_step  (w_s2)
    );

    always_comb begin
        // On expiry the timer is already stopped when the event is applied.
        w_run0 = w_fire ? 1'b0 : r_run;
        w_cnt0 = w_fire ? '0 : r_tcount;

        w_run1 = w_run0;
        w_cnt1 = w_cnt0;
        if (w_s1.hit && w_s1.start) begin
            w_run1 = 1'b1;
            w_cnt1 = w_load;
        end else if (w_s1.hit && w_s1.stop) begin
            w_run1 = 1'b0;
            w_cnt1 = '0;
        end

        w_run2 = w_run1;
        w_cnt2 = w_cnt1;
        if (w_s2.hit && w_s2.start) begin
            w_run2 = 1'b1;
            w_cnt2 = w_load;
        end else if (w_s2.hit && w_s2.stop) begin
            w_run2 = 1'b0;
            w_cnt2 = '0;
        end

        w_ent0.action_code   = w_s1.hit ? w_s1.act : AE_1;
        w_ent0.applied_event = w_ev;
        w_ent0.new_state     = w_s1.hit ? w_s1.nxt : r_state;
        w_ent0.status        = !w_s1.hit;
        w_ent0.timer_active  = w_run1;
        w_ent0.last          = !w_two;

        w_ent1.action_code   = w_s2.hit ? w_s2.act : AE_1;
        w_ent1.applied_event = EV_TC_CONF;
        w_ent1.new_state     = w_s2.hit ? w_s2.nxt : w_s1.nxt;
        w_ent1.status        = !w_s2.hit;
        w_ent1.timer_active  = w_run2;
        w_ent1.last          = 1'b1;

        if (w_acc && w_apply) begin
            w_push_n = w_two ? 2'd2 : 2'd1;
        end else begin
            w_push_n = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_artim  <= '0;
            r_state  <= ST_S1;
            r_run    <= 1'b0;
            r_tcount <= '0;
        end else begin
            if (i_cfg_we) begin
                r_artim <= i_cfg_wdata;
            end
            if (w_acc) begin
                if (w_apply) begin
                    if (w_two) begin
                        r_state  <= w_ent1.new_state;
                        r_run    <= w_run2;
                        r_tcount <= w_cnt2;
                    end else begin
                        r_state  <= w_ent0.new_state;
                        r_run    <= w_run1;
                        r_tcount <= w_cnt1;
                    end
                end else if (r_run && (r_tcount != '0)) begin
                    r_tcount <= r_tcount - TIMER_BITS'(1);
                end
            end
        end
    end

    asc_fsm_rq u_rq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_push_n),
        .i_ent0   (w_ent0),
        .i_ent1   (w_ent1),
        .o_room   (w_room),
        .o_res    (o_res)
    );

    `ASC_ASSERT_IMPL(a_stopped_zero, i_clk, i_rst_n, !r_run, r_tcount == '0)
    `ASC_ASSERT_IMPL(a_state_range, i_clk, i_rst_n, 1'b1, r_state <= ST_S13)
    `ASC_ASSERT_NEXT(a_assoc_pair, i_clk, i_rst_n, w_acc && w_two_req && r_state == ST_S1, r_state == ST_S5)
    `ASC_ASSERT_NEXT(a_miss_keeps, i_clk, i_rst_n, w_acc && w_apply && !w_s1.hit, r_state == $past(r_state))

endmodule

`default_nettype wire

// File: tb/sv/association_protocol_fsm_test.sv
`timescale 1ns / 1ps

module association_protocol_fsm_test;
    import asc_fsm_pkg::*;

    localparam int          RANDOM_ITEMS  = 1850;
    localparam int          RANDOM_PHASES = 6;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          PRINT_LIMIT   = 40;
    // A failed lookup reports action code zero, which is the encoding of AE_1.
    localparam logic [4:0]  NO_ACTION     = AE_1;
    localparam logic [4:0]  EV_CODE_TOP   = 5'd31;
    localparam logic [4:0]  EV_CODE_SPARE = 5'd19;
    localparam logic [7:0]  PDU_NONE      = 8'h00;
    localparam logic [7:0]  PDU_ALL_ONES  = 8'hFF;
    localparam logic [15:0] ARTIM_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] code;
        logic [7:0] ptype;
        logic       guard;
    } t_proto_item;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    asc_fsm_req_if req_ch ();
    asc_fsm_res_if res_ch ();

    association_protocol_fsm dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Predicted state of the association machine and its ARTIM timer.
    logic [3:0]  fsm_state     = ST_S1;
    logic [15:0] artim_len     = '0;
    logic [15:0] artim_count   = '0;
    logic        artim_running = 1'b0;

    t_res awaited_results[$];
    int   mismatch_count = 0;
    bit   src_idle       = 1'b1;
    bit   snk_idle       = 1'b1;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [9:0] arc(input logic [4:0] act, input logic [3:0] nxt);
        return {1'b1, act, nxt};
    endfunction

    // Returns {hit, action, next state}; all zero when the state has no arc for the event.
    function automatic logic [9:0] find_transition(input logic [3:0] st, input logic [4:0] ev);
        logic [9:0] r;
        r = '0;
        case (st)
            ST_S1: begin
                if (ev == EV_RQ_LOC) r = arc(AE_1, ST_S4);
                else if (ev == EV_TC_IND) r = arc(AE_5, ST_S2);
            end
            ST_S2: begin
                if (ev inside {EV_AC_REM, EV_RJ_REM, EV_DT_REM, EV_RLQ_REM, EV_RLP_REM,
                               EV_INVALID})
                    r = arc(AA_1, ST_S13);
                else if (ev == EV_RQ_REM) r = arc(AE_6, ST_S3);
                else if (ev == EV_AB_REM || ev == EV_ARTIM) r = arc(AA_2, ST_S1);
                else if (ev == EV_TC_CLOSED) r = arc(AA_5, ST_S1);
            end
            ST_S4: begin
                if (ev == EV_TC_CONF) r = arc(AE_2, ST_S5);
                else if (ev == EV_AB_LOC) r = arc(AA_2, ST_S1);
                else if (ev == EV_TC_CLOSED) r = arc(AA_4, ST_S1);
            end
            ST_S13: begin
                if (ev inside {EV_AC_REM, EV_RJ_REM, EV_DT_REM, EV_RLQ_REM, EV_RLP_REM})
                    r = arc(AA_6, ST_S13);
                else if (ev == EV_RQ_REM || ev == EV_INVALID) r = arc(AA_7, ST_S13);
                else if (ev == EV_AB_REM || ev == EV_ARTIM) r = arc(AA_2, ST_S1);
                else if (ev == EV_TC_CLOSED) r = arc(AR_5, ST_S1);
            end
            ST_S3, ST_S5, ST_S6, ST_S7, ST_S8, ST_S9, ST_S10, ST_S11, ST_S12: begin
                // These states share the abort arcs; the state's own arcs override them below.
                if (ev inside {EV_AC_REM, EV_RJ_REM, EV_RQ_REM, EV_DT_REM, EV_RLQ_REM,
                               EV_RLP_REM, EV_INVALID})
                    r = arc(AA_8, ST_S13);
                else if (ev == EV_AB_LOC) r = arc(AA_1, ST_S13);
                else if (ev == EV_AB_REM) r = arc(AA_3, ST_S1);
                else if (ev == EV_TC_CLOSED) r = arc(AA_4, ST_S1);
                case (st)
                    ST_S3: begin
                        if (ev == EV_AC_LOC) r = arc(AE_7, ST_S6);
                        else if (ev == EV_RJ_LOC) r = arc(AE_8, ST_S13);
                    end
                    ST_S5: begin
                        if (ev == EV_AC_REM) r = arc(AE_3, ST_S6);
                        else if (ev == EV_RJ_REM) r = arc(AE_4, ST_S1);
                    end
                    ST_S6: begin
                        if (ev == EV_DT_LOC) r = arc(DT_1, ST_S6);
                        else if (ev == EV_DT_REM) r = arc(DT_2, ST_S6);
                        else if (ev == EV_RLQ_LOC) r = arc(AR_1, ST_S7);
                        else if (ev == EV_RLQ_REM) r = arc(AR_2, ST_S8);
                    end
                    ST_S7: begin
                        if (ev == EV_DT_REM) r = arc(AR_6, ST_S7);
                        else if (ev == EV_RLP_REM) r = arc(AR_3, ST_S1);
                        // Both sides asked for release at once; that collision is not handled.
                        else if (ev == EV_RLQ_REM) r = '0;
                    end
                    ST_S8: begin
                        if (ev == EV_DT_LOC) r = arc(AR_7, ST_S8);
                        else if (ev == EV_RLP_LOC) r = arc(AR_4, ST_S13);
                    end
                    ST_S9: begin
                        if (ev == EV_RLP_LOC) r = arc(AR_9, ST_S11);
                    end
                    ST_S10: begin
                        if (ev == EV_RLP_REM) r = arc(AR_10, ST_S12);
                    end
                    ST_S11: begin
                        if (ev == EV_RLP_REM) r = arc(AR_3, ST_S1);
                    end
                    ST_S12: begin
                        if (ev == EV_RLP_LOC) r = arc(AR_4, ST_S13);
                    end
                    default: ;
                endcase
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] pdu_event(input bit from_local, input logic [7:0] ptype);
        case (ptype)
            PDU_ASSOC_RQ: return from_local ? EV_RQ_LOC : EV_RQ_REM;
            PDU_ASSOC_AC: return from_local ? EV_AC_LOC : EV_AC_REM;
            PDU_ASSOC_RJ: return from_local ? EV_RJ_LOC : EV_RJ_REM;
            PDU_DATA_TF:  return from_local ? EV_DT_LOC : EV_DT_REM;
            PDU_REL_RQ:   return from_local ? EV_RLQ_LOC : EV_RLQ_REM;
            PDU_REL_RP:   return from_local ? EV_RLP_LOC : EV_RLP_REM;
            PDU_ABORT:    return from_local ? EV_AB_LOC : EV_AB_REM;
            default:      return EV_INVALID;
        endcase
    endfunction

    function automatic void artim_start();
        artim_count   = artim_len;
        artim_running = 1'b1;
    endfunction

    function automatic void artim_stop();
        artim_count   = '0;
        artim_running = 1'b0;
    endfunction

    // Applies one event to the predicted machine and appends its transition report.
    function automatic bit take_event(input logic [4:0] ev, input logic guard,
                                      ref t_res outs[$]);
        logic [9:0] hit_arc;
        logic [3:0] nxt;
        t_res       r;
        hit_arc = find_transition(fsm_state, ev);
        r = '0;
        r.applied_event = ev;
        if (!hit_arc[9]) begin
            r.action_code  = NO_ACTION;
            r.new_state    = fsm_state;
            r.status       = 1'b1;
            r.timer_active = artim_running;
            outs.push_back(r);
            return 1'b0;
        end
        r.action_code = hit_arc[8:4];
        nxt = hit_arc[3:0];
        if (r.action_code == AE_6) begin
            // An unacceptable request on Sta2 is rejected and waits for the close.
            if (fsm_state == ST_S2 && !guard) begin
                nxt = ST_S13;
                artim_start();
            end else begin
                artim_stop();
            end
        end else if (r.action_code inside {AE_5, AE_8, AR_4, AA_1, AA_8}) begin
            artim_start();
        end else if (r.action_code inside {AA_2, AA_5, AR_5}) begin
            artim_stop();
        end
        fsm_state      = nxt;
        r.new_state    = nxt;
        r.timer_active = artim_running;
        outs.push_back(r);
        return 1'b1;
    endfunction

    function automatic void predict_transitions(input t_proto_item it);
        t_res outs[$];
        t_res r;
        case (it.kind)
            REQ_RAW: void'(take_event(it.code, it.guard, outs));
            REQ_LOCAL: begin
                if (it.ptype == PDU_ASSOC_RQ) begin
                    // A local request also opens the transport, which confirms at once.
                    if (take_event(EV_RQ_LOC, it.guard, outs))
                        void'(take_event(EV_TC_CONF, it.guard, outs));
                end else begin
                    void'(take_event(pdu_event(1'b1, it.ptype), it.guard, outs));
                end
            end
            REQ_REMOTE: void'(take_event(pdu_event(1'b0, it.ptype), it.guard, outs));
            default: begin
                if (artim_running && artim_count != 0) begin
                    artim_count = artim_count - 1'b1;
                    if (artim_count == 0) begin
                        artim_running = 1'b0;
                        void'(take_event(EV_ARTIM, it.guard, outs));
                    end
                end
            end
        endcase
        if (outs.size() != 0) begin
            r = outs.pop_back();
            r.last = 1'b1;
            outs.push_back(r);
        end
        foreach (outs[k]) awaited_results.push_back(outs[k]);
    endfunction

    function automatic t_proto_item compose(input logic [1:0] kind, input logic [4:0] code,
                                            input logic [7:0] ptype, input logic guard);
        t_proto_item it;
        it.kind  = kind;
        it.code  = code;
        it.ptype = ptype;
        it.guard = guard;
        return it;
    endfunction

    function automatic t_proto_item tick_item();
        return compose(REQ_TICK, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
    endfunction

    // Mostly items that the current state accepts, so the walk reaches the deep states.
    function automatic t_proto_item random_item(input bit well_formed);
        t_proto_item it;
        logic [4:0]  ev;
        logic [9:0]  hit_arc;
        it = compose(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        if (!well_formed)
            return it;
        if (artim_running && $urandom_range(0, 3) == 0)
            return tick_item();
        for (int k = 0; k < 24; k++) begin
            case ($urandom_range(0, 2))
                0: begin
                    it.kind = REQ_RAW;
                    it.code = 5'($urandom_range(0, 18));
                    ev      = it.code;
                end
                1: begin
                    it.kind  = REQ_LOCAL;
                    it.ptype = 8'($urandom_range(1, 7));
                    ev       = pdu_event(1'b1, it.ptype);
                end
                default: begin
                    it.kind  = REQ_REMOTE;
                    it.ptype = 8'($urandom_range(1, 7));
                    ev       = pdu_event(1'b0, it.ptype);
                end
            endcase
            hit_arc = find_transition(fsm_state, ev);
            if (hit_arc[9])
                return it;
        end
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [4:0] got,
                                 input logic [4:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task automatic send_item(input t_proto_item it);
        int gap;
        gap = src_idle ? $urandom_range(0, 5) : 0;
        @(negedge clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid                  <= 1'b1;
        req_ch.req_type               <= it.kind;
        req_ch.event_code             <= it.code;
        req_ch.pdu_byte               <= it.ptype;
        req_ch.association_acceptable <= it.guard;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        predict_transitions(it);
    endtask

    task automatic settle_results(input int extra);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_artim_length(input logic [15:0] len);
        settle_results(SETTLE_CYCLES);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(negedge clk);
        cfg_we    <= 1'b0;
        artim_len = len;
    endtask

    // Result channel: random back-pressure, then every item is checked in order.
    initial begin
        t_res got;
        t_res want;
        int   stall;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            stall = snk_idle ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (res_ch.valid !== 1'b1);
            got.action_code   = res_ch.action_code;
            got.applied_event = res_ch.applied_event;
            got.new_state     = res_ch.new_state;
            got.status        = res_ch.status;
            got.timer_active  = res_ch.timer_active;
            got.last          = res_ch.last;
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("result with none expected: action %0d event %0d",
                                          got.action_code, got.applied_event));
            end else begin
                want = awaited_results.pop_front();
                compare_field("action_code", got.action_code, want.action_code);
                compare_field("applied_event", got.applied_event, want.applied_event);
                compare_field("new_state", 5'(got.new_state), 5'(want.new_state));
                compare_field("status", 5'(got.status), 5'(want.status));
                compare_field("timer_active", 5'(got.timer_active), 5'(want.timer_active));
                compare_field("last", 5'(got.last), 5'(want.last));
            end
        end
    end

    // Sta1 rejects everything but the two opening events; ticks do nothing there.
    task automatic test_idle_state();
        send_item(compose(REQ_RAW, EV_CODE_TOP, PDU_ALL_ONES, 1'b1));
        send_item(compose(REQ_RAW, EV_CODE_SPARE, PDU_NONE, 1'b0));
        send_item(tick_item());
        send_item(compose(REQ_REMOTE, EV_CODE_TOP, PDU_ALL_ONES, 1'b1));
        send_item(compose(REQ_LOCAL, EV_RQ_LOC, PDU_NONE, 1'b0));
    endtask

    task automatic test_requested_association();
        send_item(compose(REQ_LOCAL, EV_RQ_LOC, PDU_ASSOC_RQ, 1'b0));
        // A second request in Sta5 fails on its first step and gives one item only.
        send_item(compose(REQ_LOCAL, EV_RQ_LOC, PDU_ASSOC_RQ, 1'b1));
        send_item(compose(REQ_REMOTE, EV_RQ_LOC, PDU_ASSOC_AC, 1'b0));
        send_item(compose(REQ_LOCAL, EV_RQ_LOC, PDU_DATA_TF, 1'b0));
        send_item(compose(REQ_REMOTE, EV_RQ_LOC, PDU_DATA_TF, 1'b0));
        send_item(compose(REQ_LOCAL, EV_RQ_LOC, PDU_REL_RQ, 1'b0));
        send_item(compose(REQ_REMOTE, EV_RQ_LOC, PDU_REL_RQ, 1'b0));
        send_item(compose(REQ_REMOTE, EV_RQ_LOC, PDU_REL_RP, 1'b0));
    endtask

    task automatic test_accepted_association();
        send_item(compose(REQ_RAW, EV_TC_IND, PDU_NONE, 1'b0));
        send_item(compose(REQ_REMOTE, EV_RQ_LOC, PDU_ASSOC_RQ, 1'b1));
        send_item(compose(REQ_LOCAL, EV_RQ_LOC, PDU_ASSOC_AC, 1'b0));
        send_item(compose(REQ_REMOTE, EV_RQ_LOC, PDU_REL_RQ, 1'b0));
        send_item(compose(REQ_LOCAL, EV_RQ_LOC, PDU_DATA_TF, 1'b0));
        send_item(compose(REQ_LOCAL, EV_RQ_LOC, PDU_REL_RP, 1'b0));
        send_item(compose(REQ_RAW, EV_TC_CLOSED, PDU_NONE, 1'b0));
    endtask

    task automatic test_rejected_association();
        send_item(compose(REQ_RAW, EV_TC_IND, PDU_NONE, 1'b1));
        send_item(compose(REQ_REMOTE, EV_RQ_LOC, PDU_ASSOC_RQ, 1'b0));
        repeat (3) send_item(tick_item());
    endtask

    task automatic test_timer_extremes();
        // A zero length arms the timer but it never runs out.
        set_artim_length(16'd0);
        send_item(compose(REQ_RAW, EV_TC_IND, PDU_NONE, 1'b0));
        repeat (3) send_item(tick_item());
        send_item(compose(REQ_RAW, EV_ARTIM, PDU_NONE, 1'b0));
        set_artim_length(16'd1);
        send_item(compose(REQ_RAW, EV_TC_IND, PDU_NONE, 1'b0));
        send_item(tick_item());
        // The longest length keeps the timer running; closing the transport stops it.
        set_artim_length(ARTIM_MAX);
        send_item(compose(REQ_RAW, EV_TC_IND, PDU_NONE, 1'b0));
        repeat (3) send_item(tick_item());
        send_item(compose(REQ_RAW, EV_TC_CLOSED, PDU_NONE, 1'b0));
    endtask

    task automatic test_random_traffic();
        logic [15:0] lengths [RANDOM_PHASES];
        lengths = '{16'd2, 16'd0, 16'd1, ARTIM_MAX, 16'd5, 16'd3};
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == RANDOM_PHASES - 1)
                set_artim_length(16'($urandom_range(1, 12)));
            else
                set_artim_length(lengths[p]);
            for (int k = 0; k < RANDOM_ITEMS / RANDOM_PHASES; k++) begin
                if (k % 64 == 0) begin
                    src_idle = 1'($urandom_range(0, 1));
                    snk_idle = 1'($urandom_range(0, 1));
                end
                send_item(random_item($urandom_range(0, 9) != 0));
            end
        end
        src_idle = 1'b1;
        snk_idle = 1'b1;
    endtask

    initial begin
        rst_n                         = 1'b0;
        cfg_we                        = 1'b0;
        cfg_wdata                     = '0;
        req_ch.valid                  = 1'b0;
        req_ch.req_type               = REQ_RAW;
        req_ch.event_code             = EV_RQ_LOC;
        req_ch.pdu_byte               = PDU_NONE;
        req_ch.association_acceptable = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_artim_length(16'd3);
        test_idle_state();
        test_requested_association();
        test_accepted_association();
        test_rejected_association();
        test_timer_extremes();
        test_random_traffic();

        settle_results(SETTLE_CYCLES);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/asc_fsm_pkg.sv
hw/rtl/asc_fsm_ifs.sv
hw/rtl/asc_fsm_step.sv
hw/rtl/asc_fsm_rq.sv
hw/rtl/association_protocol_fsm.sv
tb/sv/association_protocol_fsm_test.sv
